// ===== sv/r6q_pkg.sv =====
// r6q_pkg: shared widths, payload structs and rounding helpers for the
// 6D-rotation to quaternion converter. No dependencies.
package r6q_pkg;

  localparam int IN_WIDTH   = 16;
  localparam int OUT_WIDTH  = 16;
  localparam int OFRAC      = OUT_WIDTH - 2;
  localparam int QF         = 30;           // fraction bits of internal values
  localparam int VW         = 36;           // normaliser component width
  localparam int MW         = VW;           // magnitude width
  localparam int PW         = 6;            // leading-one position width
  localparam int NW         = QF;           // normalised magnitude width
  localparam int SUMW       = 2 * NW + 2;   // sum of four squares
  localparam int RW         = NW + 1;       // square root width
  localparam int QW         = RW + 1;       // quotient width, 31 fraction bits
  localparam int BW         = 32;           // Q30 vector element width
  localparam int SQRT_STEPS = RW;
  localparam int DIV_STEPS  = QW;

  typedef struct packed {
    logic signed [IN_WIDTH-1:0] first_x;
    logic signed [IN_WIDTH-1:0] first_y;
    logic signed [IN_WIDTH-1:0] first_z;
    logic signed [IN_WIDTH-1:0] second_x;
    logic signed [IN_WIDTH-1:0] second_y;
    logic signed [IN_WIDTH-1:0] second_z;
  } r6q_rot_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] quat_x;
    logic signed [OUT_WIDTH-1:0] quat_y;
    logic signed [OUT_WIDTH-1:0] quat_z;
    logic signed [OUT_WIDTH-1:0] quat_w;
  } r6q_quat_t;

  typedef logic signed [VW-1:0] r6q_comp_t;
  typedef r6q_comp_t [3:0]      r6q_vec_t;
  typedef logic signed [BW-1:0] r6q_q30_t;
  typedef r6q_q30_t [2:0]       r6q_v3_t;
  typedef logic [3:0][QW-1:0]   r6q_quo_t;

  typedef struct packed {
    r6q_v3_t b;
  } r6q_tag_t;

  typedef struct packed {
    logic [3:0]        neg;
    logic              nz;
    r6q_tag_t          tag;
  } r6q_dv_side_t;

  typedef struct packed {
    logic [3:0][NW-1:0] mag;
    r6q_dv_side_t       dv;
  } r6q_sq_side_t;

  typedef enum logic [1:0] {BR_W, BR_X, BR_Y, BR_Z} r6q_branch_t;

  localparam r6q_comp_t QONE = VW'(1) << QF;

  // Q30 product scaled back, nearest with ties away from zero
  function automatic logic signed [34:0] rnd_q30(input logic signed [63:0] x);
    logic [63:0] m;
    logic [63:0] r;
    m = x[63] ? 64'(-x) : 64'(x);
    r = (m + (64'd1 << (QF - 1))) >> QF;
    return x[63] ? -$signed({1'b0, r[33:0]}) : $signed({1'b0, r[33:0]});
  endfunction

  // quotient with 31 fraction bits to signed Q30, rounded
  function automatic r6q_q30_t to_q30(input logic [QW-1:0] q, input logic neg,
                                      input logic nz);
    logic [QW:0] t;
    r6q_q30_t    m;
    t = {1'b0, q} + (QW+1)'(1);
    m = $signed(t[QW:1]);
    if (!nz) return '0;
    return neg ? -m : m;
  endfunction

  // quotient with 31 fraction bits to signed output format, rounded
  function automatic logic signed [OUT_WIDTH-1:0] to_out(input logic [QW-1:0] q,
                                                         input logic neg);
    logic [QW:0]                 t;
    logic signed [OUT_WIDTH-1:0] m;
    t = ({1'b0, q} >> (QW - 2 - OFRAC)) + (QW+1)'(1);
    m = $signed(t[OUT_WIDTH:1]);
    return neg ? -m : m;
  endfunction

endpackage

// ===== sv/r6q_isqrt.sv =====
// r6q_isqrt: pipelined integer square root, one result digit per stage.
// Depends on r6q_pkg.
module r6q_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        vld,
  input  logic [r6q_pkg::SUMW-1:0]    rad,
  input  r6q_pkg::r6q_sq_side_t       side,
  output logic                        res_vld,
  output logic [r6q_pkg::RW-1:0]      root,
  output r6q_pkg::r6q_sq_side_t       res_side
);
  import r6q_pkg::*;

  logic              sv  [SQRT_STEPS+1];
  logic [SUMW-1:0]   xr  [SQRT_STEPS+1];
  logic [RW+3:0]     rem [SQRT_STEPS+1];
  logic [RW-1:0]     rt  [SQRT_STEPS+1];
  r6q_sq_side_t      sd  [SQRT_STEPS+1];

  assign sv[0]  = vld;
  assign xr[0]  = rad;
  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign sd[0]  = side;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic [RW+3:0] cur;
    logic [RW+3:0] trial;

    assign cur   = {rem[k][RW+1:0], xr[k][SUMW-1 -: 2]};
    assign trial = {2'b00, rt[k], 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else if (en) begin
        sv[k+1] <= sv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (cur >= trial) begin
          rem[k+1] <= cur - trial;
          rt[k+1]  <= {rt[k][RW-2:0], 1'b1};
        end else begin
          rem[k+1] <= cur;
          rt[k+1]  <= {rt[k][RW-2:0], 1'b0};
        end
        xr[k+1] <= xr[k] << 2;
        sd[k+1] <= sd[k];
      end
    end
  end

  assign res_vld  = sv[SQRT_STEPS];
  assign root     = rt[SQRT_STEPS];
  assign res_side = sd[SQRT_STEPS];

endmodule

// ===== sv/r6q_div.sv =====
// r6q_div: four-lane pipelined restoring divider, magnitude over norm,
// one quotient bit per stage. Depends on r6q_pkg.
module r6q_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      vld,
  input  logic [3:0][r6q_pkg::NW-1:0] mag,
  input  logic [r6q_pkg::RW-1:0]    norm,
  input  r6q_pkg::r6q_dv_side_t     side,
  output logic                      res_vld,
  output r6q_pkg::r6q_quo_t         quo,
  output r6q_pkg::r6q_dv_side_t     res_side
);
  import r6q_pkg::*;

  logic                 sv [DIV_STEPS+1];
  logic [3:0][RW-1:0]   rr [DIV_STEPS+1];
  r6q_quo_t             qq [DIV_STEPS+1];
  logic [RW-1:0]        nn [DIV_STEPS+1];
  r6q_dv_side_t         sd [DIV_STEPS+1];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      rr[0][j] = RW'(mag[j]);
    end
  end

  assign sv[0] = vld;
  assign qq[0] = '0;
  assign nn[0] = norm;
  assign sd[0] = side;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    localparam int SH = (k == 0) ? 0 : 1;
    logic [3:0][RW:0] t;
    logic [3:0][RW:0] diff;
    logic [3:0]       ge;

    always_comb begin
      for (int j = 0; j < 4; j++) begin
        t[j]    = {1'b0, rr[k][j]} << SH;
        ge[j]   = t[j] >= {1'b0, nn[k]};
        diff[j] = t[j] - {1'b0, nn[k]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else if (en) begin
        sv[k+1] <= sv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int j = 0; j < 4; j++) begin
          rr[k+1][j] <= ge[j] ? diff[j][RW-1:0] : t[j][RW-1:0];
          qq[k+1][j] <= {qq[k][j][QW-2:0], ge[j]};
        end
        nn[k+1] <= nn[k];
        sd[k+1] <= sd[k];
      end
    end
  end

  assign res_vld  = sv[DIV_STEPS];
  assign quo      = qq[DIV_STEPS];
  assign res_side = sd[DIV_STEPS];

endmodule

// ===== sv/r6q_uvec.sv =====
// r6q_uvec: vector normaliser (up to four lanes): block shift, sum of
// squares, square root, per-lane divide. Depends on r6q_pkg, r6q_isqrt, r6q_div.
module r6q_uvec (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   vld,
  input  r6q_pkg::r6q_vec_t      vec,
  input  r6q_pkg::r6q_tag_t      tag,
  output logic                   res_vld,
  output r6q_pkg::r6q_quo_t      quo,
  output logic [3:0]             neg,
  output logic                   nz,
  output r6q_pkg::r6q_tag_t      res_tag
);
  import r6q_pkg::*;

  logic [7:1]           sv;
  logic [3:0][MW-1:0]   mag1, mag2, mag3;
  logic [MW-1:0]        orv2;
  logic [PW-1:0]        pos3, pos_c;
  logic [3:0][NW-1:0]   nm4, nm5, nm6, nm7, nm_c;
  logic [3:0][2*NW-1:0] sq5;
  logic [1:0][2*NW:0]   ps6;
  logic [SUMW-1:0]      sum7;
  r6q_dv_side_t         sd1, sd2, sd3, sd4, sd5, sd6, sd7;

  logic                 sq_vld;
  logic [RW-1:0]        root;
  r6q_sq_side_t         sq_side, sq_res;
  r6q_dv_side_t         dv_res;

  // highest set bit of the OR is the leading one of the largest magnitude
  always_comb begin
    pos_c = '0;
    for (int i = 0; i < MW; i++) begin
      if (orv2[i]) pos_c = PW'(i);
    end
  end

  always_comb begin
    logic [MW-1:0] sh;
    for (int j = 0; j < 4; j++) begin
      if (pos3 >= PW'(NW - 1)) sh = mag3[j] >> (pos3 - PW'(NW - 1));
      else                     sh = mag3[j] << (PW'(NW - 1) - pos3);
      nm_c[j] = sh[NW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= '0;
    end else if (en) begin
      sv <= {sv[6:1], vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        mag1[j]    <= vec[j][VW-1] ? MW'(-vec[j]) : MW'(vec[j]);
        sd1.neg[j] <= vec[j][VW-1];
      end
      sd1.nz  <= |{vec[0], vec[1], vec[2], vec[3]};
      sd1.tag <= tag;

      mag2 <= mag1;
      orv2 <= mag1[0] | mag1[1] | mag1[2] | mag1[3];
      sd2  <= sd1;

      mag3 <= mag2;
      pos3 <= pos_c;
      sd3  <= sd2;

      nm4 <= nm_c;
      sd4 <= sd3;

      for (int j = 0; j < 4; j++) begin
        sq5[j] <= nm4[j] * nm4[j];
      end
      nm5 <= nm4;
      sd5 <= sd4;

      ps6[0] <= {1'b0, sq5[0]} + {1'b0, sq5[1]};
      ps6[1] <= {1'b0, sq5[2]} + {1'b0, sq5[3]};
      nm6    <= nm5;
      sd6    <= sd5;

      sum7 <= {1'b0, ps6[0]} + {1'b0, ps6[1]};
      nm7  <= nm6;
      sd7  <= sd6;
    end
  end

  always_comb begin
    sq_side.mag = nm7;
    sq_side.dv  = sd7;
  end

  r6q_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vld      (sv[7]),
    .rad      (sum7),
    .side     (sq_side),
    .res_vld  (sq_vld),
    .root     (root),
    .res_side (sq_res)
  );

  r6q_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vld      (sq_vld),
    .mag      (sq_res.mag),
    .norm     (root),
    .side     (sq_res.dv),
    .res_vld  (res_vld),
    .quo      (quo),
    .res_side (dv_res)
  );

  assign neg     = dv_res.neg;
  assign nz      = dv_res.nz;
  assign res_tag = dv_res.tag;

endmodule

// ===== sv/r6q_skid.sv =====
// r6q_skid: output register with one skid entry; decouples the receiver's
// stall from the pipeline advance. Depends on r6q_pkg.
module r6q_skid (
  input  logic                clk,
  input  logic                rst,
  input  logic                vld,
  input  r6q_pkg::r6q_quat_t  item,
  output logic                full,
  output logic                res_vld,
  output r6q_pkg::r6q_quat_t  res,
  input  logic                res_stall
);
  import r6q_pkg::*;

  r6q_quat_t hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      full    <= 1'b0;
      res_vld <= 1'b0;
    end else if (!res_vld || !res_stall) begin
      if (full) begin
        res_vld <= 1'b1;
        full    <= 1'b0;
      end else begin
        res_vld <= vld;
      end
    end else if (vld && !full) begin
      full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!res_vld || !res_stall) begin
      res <= full ? hold : item;
    end else if (vld && !full) begin
      hold <= item;
    end
  end

endmodule

// ===== sv/rot6d_to_unit_quaternion_top.sv =====
// rot6d_to_unit_quaternion_top: 6D rotation to unit quaternion converter.
// Depends on r6q_pkg, r6q_uvec, r6q_skid.
//
// Usage
//   rot channel (rot_valid / rot_stall / rot): one 6D rotation per
//   transaction, two column vectors in signed Q3.12.
//   quat channel (quat_valid / quat_stall / quat): one unit quaternion per
//   transaction, x y z w in signed Q1.14. A degenerate result is identity.
//   One transaction in gives exactly one out, in order.
// Stages: three vector normalisers of 70 stages each (7 shift/square/sum
//   stages, 31 root-digit stages, 32 quotient-bit stages); dot product and
//   projection take 7, cross product 4, branch select 2, output register 1.
// Throughput: one transaction per cycle while rot_stall is low; every
//   stage advances together.
// Stall: a receiver stall parks one result in the skid entry; rot_stall is
//   that entry's full flag, so it is registered and the whole pipeline
//   freezes while it is set. Nothing is dropped or repeated.
// Reset: rst (synchronous) clears all valid flags and the skid full flag;
//   data registers are not reset and no transaction in flight survives.
module rot6d_to_unit_quaternion_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                rot_valid,
  output logic                rot_stall,
  input  r6q_pkg::r6q_rot_t   rot,
  output logic                quat_valid,
  input  logic                quat_stall,
  output r6q_pkg::r6q_quat_t  quat
);
  import r6q_pkg::*;

  localparam r6q_q30_t QB = BW'(1) << QF;

  logic en;        // whole-pipeline advance
  logic full;

  // normaliser signals (both columns side by side, then u3 and u4)
  r6q_vec_t   u1_vec, u2_vec, u3_vec;
  r6q_quo_t   u1_q, u2_q, u3_q, u4_q;
  logic [3:0] u1_neg, u2_neg, u3_neg, u4_neg;
  logic       u1_nz, u2_nz, u3_nz, u4_nz;
  logic       u1_valid, u2_valid, u3_valid, u4_valid;
  r6q_tag_t   u3_tag_in, u3_tag;

  // projection stages
  logic [1:7]             vt;
  r6q_v3_t                b1_s [1:7];
  r6q_v3_t                u2_s [1:6];
  logic signed [63:0]     pr2 [3];
  logic signed [63:0]     ds3;
  r6q_q30_t               dot4;
  logic signed [63:0]     pd5 [3];
  r6q_q30_t               rp6 [3];
  r6q_comp_t              p7  [3];

  // cross product stages
  logic [1:4]             vc;
  r6q_v3_t                b1c [1:4];
  r6q_v3_t                b2c [1:4];
  logic signed [63:0]     cp2 [6];
  logic signed [63:0]     cd3 [3];
  r6q_v3_t                b3c4;

  // branch select stages
  logic [1:2]             vk;
  r6q_q30_t               rk [9];
  r6q_branch_t            br1, br_c;
  r6q_vec_t               sqk2;
  logic signed [BW+1:0]   trace_c;

  r6q_quat_t              res_c;

  assign en        = !full;
  assign rot_stall = full;

  always_comb begin
    u1_vec[0] = VW'(rot.first_x);
    u1_vec[1] = VW'(rot.first_y);
    u1_vec[2] = VW'(rot.first_z);
    u1_vec[3] = '0;
    u2_vec[0] = VW'(rot.second_x);
    u2_vec[1] = VW'(rot.second_y);
    u2_vec[2] = VW'(rot.second_z);
    u2_vec[3] = '0;
  end

  r6q_uvec u_norm_a (
    .clk (clk), .rst (rst), .en (en),
    .vld (rot_valid && !rot_stall), .vec (u1_vec), .tag ('0),
    .res_vld (u1_valid), .quo (u1_q), .neg (u1_neg), .nz (u1_nz), .res_tag ()
  );

  r6q_uvec u_norm_b (
    .clk (clk), .rst (rst), .en (en),
    .vld (rot_valid && !rot_stall), .vec (u2_vec), .tag ('0),
    .res_vld (u2_valid), .quo (u2_q), .neg (u2_neg), .nz (u2_nz), .res_tag ()
  );

  // remainder of column two after removing its b1 component; b1 rides along
  always_comb begin
    u3_vec[0] = p7[0];
    u3_vec[1] = p7[1];
    u3_vec[2] = p7[2];
    u3_vec[3] = '0;
    u3_tag_in.b = b1_s[7];
  end

  r6q_uvec u_norm_p (
    .clk (clk), .rst (rst), .en (en),
    .vld (vt[7]), .vec (u3_vec), .tag (u3_tag_in),
    .res_vld (u3_valid), .quo (u3_q), .neg (u3_neg), .nz (u3_nz), .res_tag (u3_tag)
  );

  // Shepperd branch: trace first, then largest diagonal, later one on a tie
  always_comb begin
    trace_c = (BW+2)'($signed(b1c[4][0])) + (BW+2)'($signed(b2c[4][1]))
            + (BW+2)'($signed(b3c4[2]));
    priority if (trace_c > 0) begin
      br_c = BR_W;
    end else if ($signed(b1c[4][0]) > $signed(b2c[4][1]) &&
                 $signed(b1c[4][0]) > $signed(b3c4[2])) begin
      br_c = BR_X;
    end else if ($signed(b2c[4][1]) > $signed(b3c4[2])) begin
      br_c = BR_Y;
    end else begin
      br_c = BR_Z;
    end
  end

  r6q_uvec u_norm_q (
    .clk (clk), .rst (rst), .en (en),
    .vld (vk[2]), .vec (sqk2), .tag ('0),
    .res_vld (u4_valid), .quo (u4_q), .neg (u4_neg), .nz (u4_nz), .res_tag ()
  );

  // all-zero scaled quaternion gives identity
  always_comb begin
    if (u4_nz) begin
      res_c.quat_x = to_out(u4_q[0], u4_neg[0]);
      res_c.quat_y = to_out(u4_q[1], u4_neg[1]);
      res_c.quat_z = to_out(u4_q[2], u4_neg[2]);
      res_c.quat_w = to_out(u4_q[3], u4_neg[3]);
    end else begin
      res_c.quat_x = '0;
      res_c.quat_y = '0;
      res_c.quat_z = '0;
      res_c.quat_w = OUT_WIDTH'(1) << OFRAC;
    end
  end

  r6q_skid u_skid (
    .clk (clk), .rst (rst),
    .vld (u4_valid), .item (res_c), .full (full),
    .res_vld (quat_valid), .res (quat), .res_stall (quat_stall)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vt <= '0;
      vc <= '0;
      vk <= '0;
    end else if (en) begin
      vt <= {u1_valid, vt[1:6]};
      vc <= {u3_valid, vc[1:3]};
      vk <= {vc[4], vk[1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // T1: round the unit columns to Q30
      for (int j = 0; j < 3; j++) begin
        b1_s[1][j] <= to_q30(u1_q[j], u1_neg[j], u1_nz);
        u2_s[1][j] <= to_q30(u2_q[j], u2_neg[j], u2_nz);
      end
      for (int s = 2; s <= 7; s++) b1_s[s] <= b1_s[s-1];
      for (int s = 2; s <= 6; s++) u2_s[s] <= u2_s[s-1];
      // T2..T4: dot product
      for (int j = 0; j < 3; j++) pr2[j] <= $signed(b1_s[1][j]) * $signed(u2_s[1][j]);
      ds3  <= pr2[0] + pr2[1] + pr2[2];
      dot4 <= BW'(rnd_q30(ds3));
      // T5..T7: subtract the projection
      for (int j = 0; j < 3; j++) begin
        pd5[j] <= dot4 * $signed(b1_s[4][j]);
        rp6[j] <= BW'(rnd_q30(pd5[j]));
        p7[j]  <= VW'($signed(u2_s[6][j])) - VW'(rp6[j]);
      end

      // C1..C4: third column b1 x b2
      b1c[1] <= u3_tag.b;
      for (int j = 0; j < 3; j++) b2c[1][j] <= to_q30(u3_q[j], u3_neg[j], u3_nz);
      for (int s = 2; s <= 4; s++) begin
        b1c[s] <= b1c[s-1];
        b2c[s] <= b2c[s-1];
      end
      cp2[0] <= $signed(b1c[1][1]) * $signed(b2c[1][2]);
      cp2[1] <= $signed(b1c[1][2]) * $signed(b2c[1][1]);
      cp2[2] <= $signed(b1c[1][2]) * $signed(b2c[1][0]);
      cp2[3] <= $signed(b1c[1][0]) * $signed(b2c[1][2]);
      cp2[4] <= $signed(b1c[1][0]) * $signed(b2c[1][1]);
      cp2[5] <= $signed(b1c[1][1]) * $signed(b2c[1][0]);
      cd3[0] <= cp2[0] - cp2[1];
      cd3[1] <= cp2[2] - cp2[3];
      cd3[2] <= cp2[4] - cp2[5];
      for (int j = 0; j < 3; j++) b3c4[j] <= BW'(rnd_q30(cd3[j]));

      // K1: matrix rows, branch choice
      for (int r = 0; r < 3; r++) begin
        rk[r*3 + 0] <= b1c[4][r];
        rk[r*3 + 1] <= b2c[4][r];
        rk[r*3 + 2] <= b3c4[r];
      end
      br1 <= br_c;

      // K2: scaled quaternion of the chosen branch
      unique case (br1)
        BR_W: begin
          sqk2[0] <= VW'(rk[7]) - VW'(rk[5]);
          sqk2[1] <= VW'(rk[2]) - VW'(rk[6]);
          sqk2[2] <= VW'(rk[3]) - VW'(rk[1]);
          sqk2[3] <= QONE + VW'(rk[0]) + VW'(rk[4]) + VW'(rk[8]);
        end
        BR_X: begin
          sqk2[0] <= QONE + VW'(rk[0]) - VW'(rk[4]) - VW'(rk[8]);
          sqk2[1] <= VW'(rk[1]) + VW'(rk[3]);
          sqk2[2] <= VW'(rk[2]) + VW'(rk[6]);
          sqk2[3] <= VW'(rk[7]) - VW'(rk[5]);
        end
        BR_Y: begin
          sqk2[0] <= VW'(rk[1]) + VW'(rk[3]);
          sqk2[1] <= QONE + VW'(rk[4]) - VW'(rk[0]) - VW'(rk[8]);
          sqk2[2] <= VW'(rk[5]) + VW'(rk[7]);
          sqk2[3] <= VW'(rk[2]) - VW'(rk[6]);
        end
        default: begin
          sqk2[0] <= VW'(rk[2]) + VW'(rk[6]);
          sqk2[1] <= VW'(rk[5]) + VW'(rk[7]);
          sqk2[2] <= QONE + VW'(rk[8]) - VW'(rk[0]) - VW'(rk[4]);
          sqk2[3] <= VW'(rk[3]) - VW'(rk[1]);
        end
      endcase
    end
  end

  // the two column normalisers must stay in lockstep
  a_lockstep: assert property (@(posedge clk) disable iff (rst)
    u1_valid == u2_valid)
    else $error("column normalisers out of step");

  // a normalised first column never exceeds one in any component
  a_b1_unit: assert property (@(posedge clk) disable iff (rst)
    vt[1] |-> ($signed(b1_s[1][0]) <= QB && $signed(b1_s[1][0]) >= -QB &&
               $signed(b1_s[1][1]) <= QB && $signed(b1_s[1][1]) >= -QB &&
               $signed(b1_s[1][2]) <= QB && $signed(b1_s[1][2]) >= -QB))
    else $error("b1 component out of range");

  // a full skid entry implies a result held on the output
  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    rot_stall |-> quat_valid)
    else $error("skid entry full with no output held");

endmodule
